>>> sv/unhm_pkg.sv
// ----------------------------------------------------------------------------
// unhm_pkg
// Shared constants and types for the nearest real UMI search block.
// ----------------------------------------------------------------------------
`default_nettype none

package unhm_pkg;

   localparam int MAX_UMIS_DEF = 64;
   localparam int UMI_LEN_DEF  = 10;

   // fixed field widths of the ports
   localparam int BASE_FIELD_LEN = 10;
   localparam int BASES_W        = 2 * BASE_FIELD_LEN;
   localparam int MASK_W         = BASE_FIELD_LEN;
   localparam int COUNT_W        = 24;
   localparam int INDEX_W        = 6;
   localparam int DIST_W         = 4;
   localparam int MAXD_W         = 4;

   localparam logic [MAXD_W-1:0] MAX_DIST_RST = 4'd1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RD_BAD,
      ST_CHK_BAD,
      ST_SCAN,
      ST_WAIT1,
      ST_WAIT2,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic bad_load;
      logic cand_vld;
   } scan_ctl_type;

   typedef struct packed {
      logic              found;
      logic [DIST_W-1:0] distance;
   } best_type;

endpackage

`default_nettype wire

>>> sv/umi_nearest_hamming_merge_core.sv
// ----------------------------------------------------------------------------
// umi_nearest_hamming_merge_core
// Loads one gene's UMI set into memory, then finds for every bad UMI the
// nearest real UMI and emits one result word per bad UMI.
// ----------------------------------------------------------------------------
// Load: one input word per cycle. After the word with last_umi, the search
// visits each entry up to the last bad one; for each bad UMI it reads every
// entry of the set as a candidate (one candidate read per memory cycle) and
// waits while the result register is stalled. No input is taken meanwhile.
// Reset clears the entry count, the control state and the output valid and
// sets the merge distance limit to 1; memory contents are not cleared.
`default_nettype none

module umi_nearest_hamming_merge_core #(
   parameter int MAX_UMIS = unhm_pkg::MAX_UMIS_DEF,
   parameter int UMI_LEN  = unhm_pkg::UMI_LEN_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [unhm_pkg::BASES_W-1:0]  req_umi_bases,
   input  wire logic [unhm_pkg::MASK_W-1:0]   req_umi_n_mask,
   input  wire logic [unhm_pkg::COUNT_W-1:0]  req_read_count,
   input  wire logic                          req_last_umi,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [unhm_pkg::INDEX_W-1:0]  rsp_bad_index,
   output logic      [unhm_pkg::INDEX_W-1:0]  rsp_target_index,
   output logic      [unhm_pkg::DIST_W-1:0]   rsp_best_distance,
   output logic                               rsp_matched,
   output logic                               rsp_last_result,
   input  wire logic                          csr_wr_en,
   input  wire logic [unhm_pkg::MAXD_W-1:0]   csr_wr_data
);

   import unhm_pkg::*;

   localparam int EffLen = (UMI_LEN < BASE_FIELD_LEN) ? UMI_LEN : BASE_FIELD_LEN;
   localparam int IdxW   = $clog2(MAX_UMIS);
   localparam int CntW   = $clog2(MAX_UMIS + 1);
   localparam int WordW  = COUNT_W + EffLen + 2 * EffLen;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   n_ff, n_in;
   logic [IdxW-1:0]   i_ff, i_in;
   logic [IdxW-1:0]   j_ff, j_in;
   logic [IdxW-1:0]   last_bad_ff, last_bad_in;
   logic              any_bad_ff, any_bad_in;
   logic [MAXD_W-1:0] max_dist_ff;

   logic              issue_ff;
   logic [IdxW-1:0]   issue_idx_ff;

   logic              wr_en;
   logic [WordW-1:0]  wr_data;
   logic              rd_en;
   logic [IdxW-1:0]   rd_addr;
   logic [WordW-1:0]  rd_data;
   logic [2*EffLen-1:0] rd_bases;
   logic [EffLen-1:0] rd_mask;
   logic [COUNT_W-1:0] rd_count;

   scan_ctl_type      ctl;
   best_type          best;
   logic [IdxW-1:0]   best_index;

   logic              accept;
   logic              store_ok;
   logic              item_bad;
   logic              scan_last;
   logic              out_free;
   logic              emit_load;
   logic              matched;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_bad_ff;
   logic [INDEX_W-1:0] rsp_target_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_matched_ff;
   logic              rsp_last_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign store_ok  = (n_ff != CntW'(MAX_UMIS));
   assign item_bad  = |req_umi_n_mask[EffLen-1:0];
   assign wr_data   = {req_read_count, req_umi_n_mask[EffLen-1:0],
                       req_umi_bases[2*EffLen-1:0]};

   assign rd_bases  = rd_data[2*EffLen-1:0];
   assign rd_mask   = rd_data[3*EffLen-1:2*EffLen];
   assign rd_count  = rd_data[WordW-1:3*EffLen];

   assign scan_last = ((CntW'(j_ff) + CntW'(1)) == n_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign matched   = best.found && (best.distance <= max_dist_ff);

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      last_bad_in = last_bad_ff;
      any_bad_in  = any_bad_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = i_ff;
      ctl         = '0;
      emit_load   = 1'b0;
      ctl.cand_vld = issue_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               // drop words once the set is full
               if (store_ok) begin
                  wr_en = 1'b1;
                  n_in  = n_ff + CntW'(1);
                  if (item_bad) begin
                     last_bad_in = n_ff[IdxW-1:0];
                     any_bad_in  = 1'b1;
                  end
               end
               if (req_last_umi) begin
                  if (any_bad_ff || (store_ok && item_bad)) begin
                     i_in     = '0;
                     state_in = ST_RD_BAD;
                  end else begin
                     n_in       = '0;
                     any_bad_in = 1'b0;
                  end
               end
            end
         end
         ST_RD_BAD: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = ST_CHK_BAD;
         end
         ST_CHK_BAD: begin
            if (rd_mask != '0) begin
               ctl.bad_load = 1'b1;
               j_in         = '0;
               state_in     = ST_SCAN;
            end else begin
               i_in     = i_ff + IdxW'(1);
               state_in = ST_RD_BAD;
            end
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = j_ff;
            j_in    = j_ff + IdxW'(1);
            if (scan_last) begin
               state_in = ST_WAIT1;
            end
         end
         ST_WAIT1: begin
            state_in = ST_WAIT2;
         end
         ST_WAIT2: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               emit_load = 1'b1;
               if (i_ff == last_bad_ff) begin
                  n_in       = '0;
                  any_bad_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  i_in     = i_ff + IdxW'(1);
                  state_in = ST_RD_BAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         n_ff        <= '0;
         any_bad_ff  <= 1'b0;
         issue_ff    <= 1'b0;
         max_dist_ff <= MAX_DIST_RST;
      end else begin
         state_ff   <= state_in;
         n_ff       <= n_in;
         any_bad_ff <= any_bad_in;
         issue_ff   <= (state_ff == ST_SCAN);
         if (csr_wr_en) begin
            max_dist_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      last_bad_ff  <= last_bad_in;
      issue_idx_ff <= j_ff;
   end

   // output register: hold while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_bad_ff     <= INDEX_W'(i_ff);
         rsp_target_ff  <= matched ? INDEX_W'(best_index) : '0;
         rsp_dist_ff    <= best.found ? best.distance : '0;
         rsp_matched_ff <= matched;
         rsp_last_ff    <= (i_ff == last_bad_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bad_index     = rsp_bad_ff;
   assign rsp_target_index  = rsp_target_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_last_result   = rsp_last_ff;

   unhm_mem #(
      .DEPTH (MAX_UMIS),
      .WIDTH (WordW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (n_ff[IdxW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   unhm_best #(
      .MAX_UMIS (MAX_UMIS),
      .UMI_LEN  (UMI_LEN)
   ) u_best (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cand_index (issue_idx_ff),
      .rd_bases   (rd_bases),
      .rd_mask    (rd_mask),
      .rd_count   (rd_count),
      .best       (best),
      .best_index (best_index)
   );

endmodule

`default_nettype wire

>>> sv/unhm_mem.sv
// ----------------------------------------------------------------------------
// unhm_mem
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module unhm_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 54
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/unhm_best.sv
// ----------------------------------------------------------------------------
// unhm_best
// Distance stage and best-candidate tracker for one bad UMI.
// ----------------------------------------------------------------------------
`default_nettype none

module unhm_best #(
   parameter int MAX_UMIS = unhm_pkg::MAX_UMIS_DEF,
   parameter int UMI_LEN  = unhm_pkg::UMI_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire unhm_pkg::scan_ctl_type              ctl,
   input  wire logic [$clog2(MAX_UMIS)-1:0]         cand_index,
   input  wire logic [2*((UMI_LEN < unhm_pkg::BASE_FIELD_LEN) ?
                        UMI_LEN : unhm_pkg::BASE_FIELD_LEN)-1:0] rd_bases,
   input  wire logic [((UMI_LEN < unhm_pkg::BASE_FIELD_LEN) ?
                        UMI_LEN : unhm_pkg::BASE_FIELD_LEN)-1:0] rd_mask,
   input  wire logic [unhm_pkg::COUNT_W-1:0]        rd_count,
   output unhm_pkg::best_type                       best,
   output logic      [$clog2(MAX_UMIS)-1:0]         best_index
);

   import unhm_pkg::*;

   localparam int EffLen = (UMI_LEN < BASE_FIELD_LEN) ? UMI_LEN : BASE_FIELD_LEN;
   localparam int IdxW   = $clog2(MAX_UMIS);

   logic [2*EffLen-1:0] bad_bases_ff;
   logic [EffLen-1:0]   bad_mask_ff;

   logic [EffLen-1:0]   mismatch;
   logic [DIST_W-1:0]   cand_dist;

   logic                s1_vld_ff;
   logic [DIST_W-1:0]   s1_dist_ff;
   logic [COUNT_W-1:0]  s1_count_ff;
   logic [IdxW-1:0]     s1_idx_ff;

   logic                found_ff;
   logic [DIST_W-1:0]   best_d_ff;
   logic [COUNT_W-1:0]  best_c_ff;
   logic [IdxW-1:0]     best_t_ff;
   logic                take;

   // an N in the bad UMI always mismatches
   always_comb begin
      for (int p = 0; p < EffLen; p++) begin
         mismatch[p] = bad_mask_ff[p] || (bad_bases_ff[2*p +: 2] != rd_bases[2*p +: 2]);
      end
      cand_dist = DIST_W'($countones(mismatch));
   end

   always_ff @(posedge clock) begin
      if (ctl.bad_load) begin
         bad_bases_ff <= rd_bases;
         bad_mask_ff  <= rd_mask;
      end
   end

   // stage 1: distance of the candidate, bad candidates dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= ctl.cand_vld && (rd_mask == '0);
      end
   end

   always_ff @(posedge clock) begin
      s1_dist_ff  <= cand_dist;
      s1_count_ff <= rd_count;
      s1_idx_ff   <= cand_index;
   end

   // stage 2: keep the nearest, then the smaller count, then the earlier load
   assign take = s1_vld_ff &&
                 (!found_ff || (s1_dist_ff < best_d_ff) ||
                  ((s1_dist_ff == best_d_ff) && (s1_count_ff < best_c_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.bad_load) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_d_ff <= s1_dist_ff;
         best_c_ff <= s1_count_ff;
         best_t_ff <= s1_idx_ff;
      end
   end

   assign best.found    = found_ff;
   assign best.distance = best_d_ff;
   assign best_index    = best_t_ff;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives gene sets of UMI words into umi_nearest_hamming_merge_core, predicts
// the nearest real UMI for every bad UMI of each set, and checks each result
// word in order. Both channels idle and stall at random, with one long
// receiver hold-off that backs the block up onto its input.
// ----------------------------------------------------------------------------

module testbench;
   import unhm_pkg::*;

   localparam int SET_DEPTH     = MAX_UMIS_DEF;
   localparam int UMI_BASES     = UMI_LEN_DEF;
   localparam int unsigned LEN_MASK = (1 << UMI_BASES) - 1;
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 800;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [BASES_W-1:0] bases;
      logic [MASK_W-1:0]  n_mask;
      logic [COUNT_W-1:0] count;
      logic               last;
   } umi_word_type;

   typedef struct packed {
      logic [INDEX_W-1:0] bad_index;
      logic [INDEX_W-1:0] target_index;
      logic [DIST_W-1:0]  best_distance;
      logic               matched;
      logic               last_result;
   } merge_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BASES_W-1:0]  req_umi_bases = '0;
   logic [MASK_W-1:0]   req_umi_n_mask = '0;
   logic [COUNT_W-1:0]  req_read_count = '0;
   logic                req_last_umi = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_bad_index;
   logic [INDEX_W-1:0]  rsp_target_index;
   logic [DIST_W-1:0]   rsp_best_distance;
   logic                rsp_matched;
   logic                rsp_last_result;
   logic                csr_wr_en = 1'b0;
   logic [MAXD_W-1:0]   csr_wr_data = '0;

   // shadow of the block's set memory and register
   logic [BASES_W-1:0]  umi_base_mem  [SET_DEPTH];
   logic [MASK_W-1:0]   umi_mask_mem  [SET_DEPTH];
   logic [COUNT_W-1:0]  umi_count_mem [SET_DEPTH];
   int unsigned         umi_fill = 0;
   logic [MAXD_W-1:0]   merge_limit = MAX_DIST_RST;

   umi_word_type        umi_words_q[$];
   merge_result_type    pending_merges[$];

   logic                req_taken = 1'b0;
   bit                  req_idle_on = 1'b0;
   bit                  rsp_idle_on = 1'b0;
   int unsigned         send_gap = 0;
   int unsigned         stall_left = 0;
   int unsigned         hold_left = 0;
   int unsigned         hold_req = 0;
   int unsigned         hold_done = 0;
   int unsigned         fail_count = 0;
   int unsigned         cycle_count = 0;

   umi_nearest_hamming_merge_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_umi_bases     (req_umi_bases),
      .req_umi_n_mask    (req_umi_n_mask),
      .req_read_count    (req_read_count),
      .req_last_umi      (req_last_umi),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bad_index     (rsp_bad_index),
      .rsp_target_index  (rsp_target_index),
      .rsp_best_distance (rsp_best_distance),
      .rsp_matched       (rsp_matched),
      .rsp_last_result   (rsp_last_result),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #1 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit umi_is_bad(int unsigned idx);
      return (int'(umi_mask_mem[idx]) & LEN_MASK) != 0;
   endfunction

   // N on the bad side always counts as a mismatch
   function automatic int unsigned umi_distance(int unsigned bad, int unsigned cand);
      int unsigned d = 0;
      for (int p = 0; p < UMI_BASES; p++) begin
         if (umi_mask_mem[bad][p] ||
             umi_base_mem[bad][2*p +: 2] != umi_base_mem[cand][2*p +: 2])
            d++;
      end
      return d;
   endfunction

   task automatic load_and_search(input umi_word_type w);
      merge_result_type   r;
      bit                 found;
      int unsigned        best_d, best_t, d, emitted;
      logic [COUNT_W-1:0] best_c;
      // drop words once the set memory is full
      if (umi_fill < SET_DEPTH) begin
         umi_base_mem[umi_fill]  = w.bases;
         umi_mask_mem[umi_fill]  = w.n_mask;
         umi_count_mem[umi_fill] = w.count;
         umi_fill++;
      end
      if (!w.last) return;
      emitted = 0;
      for (int unsigned i = 0; i < umi_fill; i++) begin
         if (!umi_is_bad(i)) continue;
         found = 1'b0;
         best_d = 0;
         best_c = '0;
         best_t = 0;
         for (int unsigned j = 0; j < umi_fill; j++) begin
            if (umi_is_bad(j)) continue;
            d = umi_distance(i, j);
            if (!found || d < best_d || (d == best_d && umi_count_mem[j] < best_c)) begin
               found = 1'b1;
               best_d = d;
               best_c = umi_count_mem[j];
               best_t = j;
            end
         end
         r.bad_index = INDEX_W'(i);
         r.matched = found && best_d <= merge_limit;
         r.target_index = r.matched ? INDEX_W'(best_t) : '0;
         r.best_distance = !found ? '0 : DIST_W'(best_d > 15 ? 15 : best_d);
         r.last_result = 1'b0;
         pending_merges.insert(pending_merges.size(), r);
         emitted++;
      end
      if (emitted > 0) pending_merges[$].last_result = 1'b1;
      umi_fill = 0;
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   // sender: advance on acceptance, hold the payload while stalled
   always @(negedge clock) begin : drive_words
      umi_word_type w;
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (umi_words_q.size() != 0) begin
            w = umi_words_q.pop_front();
            req_umi_bases  <= w.bases;
            req_umi_n_mask <= w.n_mask;
            req_read_count <= w.count;
            req_last_umi   <= w.last;
            req_valid      <= 1'b1;
            send_gap = req_idle_on ? pick_idle() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus the long hold-off on request
   always @(negedge clock) begin : drive_stall
      bit stall_now;
      stall_now = 1'b0;
      if (!reset) begin
         if (hold_req != hold_done) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
         end else begin
            if (stall_left == 0) stall_left = rsp_idle_on ? pick_idle() : 0;
            if (stall_left > 0) begin
               stall_left--;
               stall_now = 1'b1;
            end
         end
      end
      rsp_stall <= stall_now;
   end

   always @(posedge clock) begin : watch_ports
      merge_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            load_and_search('{req_umi_bases, req_umi_n_mask, req_read_count, req_last_umi});
         if (rsp_valid && !rsp_stall) begin
            if (pending_merges.size() == 0) begin
               $error("result word with none expected: bad_index %0d", rsp_bad_index);
               fail_count++;
            end else begin
               want = pending_merges.pop_front();
               check_field("bad_index", 32'(want.bad_index), 32'(rsp_bad_index));
               check_field("target_index", 32'(want.target_index),
                           32'(rsp_target_index));
               check_field("best_distance", 32'(want.best_distance),
                           32'(rsp_best_distance));
               check_field("matched", 32'(want.matched), 32'(rsp_matched));
               check_field("last_result", 32'(want.last_result), 32'(rsp_last_result));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[umi_nearest_hamming_merge_core] ERROR");
         $finish;
      end
   end

   task automatic add_word(input logic [BASES_W-1:0] bases, input logic [MASK_W-1:0] n_mask,
                           input logic [COUNT_W-1:0] count, input logic last);
      umi_word_type w;
      w = '{bases, n_mask, count, last};
      umi_words_q.insert(umi_words_q.size(), w);
   endtask

   function automatic logic [BASES_W-1:0] mutate_bases(input logic [BASES_W-1:0] b,
                                                       input int unsigned flips);
      int unsigned p;
      repeat (flips) begin
         p = $urandom_range(0, UMI_BASES - 1);
         b[2*p +: 2] ^= 2'($urandom_range(1, 3));
      end
      return b;
   endfunction

   // real UMIs plus bad ones, most of which sit a few bases away from them
   task automatic add_gene_set(input int unsigned n_words);
      logic [BASES_W-1:0] parents[$];
      logic [BASES_W-1:0] b;
      logic [MASK_W-1:0]  m;
      logic [COUNT_W-1:0] c;
      int unsigned        kind, r;
      for (int unsigned k = 0; k < n_words; k++) begin
         kind = $urandom_range(0, 9);
         m = '0;
         if (parents.size() == 0 || kind < 3) begin
            b = BASES_W'($urandom);
            parents.insert(parents.size(), b);
         end else if (kind < 5) begin
            b = mutate_bases(parents[$urandom_range(0, parents.size() - 1)],
                             $urandom_range(0, 2));
            parents.insert(parents.size(), b);
         end else if (kind < 9) begin
            b = mutate_bases(parents[$urandom_range(0, parents.size() - 1)],
                             $urandom_range(0, 2));
            repeat ($urandom_range(1, 3)) m[$urandom_range(0, UMI_BASES - 1)] = 1'b1;
         end else begin
            b = BASES_W'($urandom);
            m = MASK_W'($urandom);
         end
         r = $urandom_range(0, 9);
         if (r < 5) c = COUNT_W'($urandom_range(0, 3));
         else if (r < 6) c = '1;
         else c = COUNT_W'($urandom);
         add_word(b, m, c, k == n_words - 1);
      end
   endtask

   task automatic write_merge_limit(input logic [MAXD_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      merge_limit = value;
   endtask

   // wait out queued words and results, then let a set with no bad UMI finish
   task automatic drain_and_settle();
      while (umi_words_q.size() != 0 || req_valid || pending_merges.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [MAXD_W-1:0] limits [5];
      int unsigned       added, n;
      limits = '{4'd2, 4'd10, 4'd15, 4'd4, 4'($urandom_range(0, 15))};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limit: near match, all-N word far from everything
      add_word(20'h00000, 10'h000, 24'd5, 1'b0);
      add_word(20'hFFFFF, 10'h000, 24'hFFFFFF, 1'b0);
      add_word(20'h00000, 10'h001, 24'd0, 1'b0);
      add_word(20'hFFFFF, 10'h3FF, 24'hFFFFFF, 1'b1);
      // only bad UMIs, then only real ones, then a lone bad one
      add_word(20'h5A5A5, 10'h010, 24'd1, 1'b0);
      add_word(20'h12345, 10'h200, 24'd2, 1'b1);
      add_word(20'h0F0F0, 10'h000, 24'd3, 1'b0);
      add_word(20'hF0F0F, 10'h000, 24'd4, 1'b1);
      add_word(20'h33333, 10'h002, 24'd9, 1'b1);
      drain_and_settle();

      // zero limit: a bad UMI never matches
      write_merge_limit(4'd0);
      add_word(20'h12345, 10'h000, 24'd0, 1'b0);
      add_word(20'h12345, 10'h001, 24'd1, 1'b1);
      drain_and_settle();

      // ties: smaller count wins, then the earlier word
      write_merge_limit(4'd15);
      add_word(20'hA5C3F, 10'h000, 24'd7, 1'b0);
      add_word(20'hA5C3F ^ 20'h00010, 10'h000, 24'd3, 1'b0);
      add_word(20'hA5C3F, 10'h000, 24'd7, 1'b0);
      add_word(20'hA5C3F, 10'h000, 24'd3, 1'b0);
      add_word(20'hA5C3F, 10'h000, 24'd3, 1'b0);
      add_word(20'hA5C3F, 10'h020, 24'd9, 1'b0);
      add_word(20'hA5C3F, 10'h004, 24'd0, 1'b1);
      drain_and_settle();

      for (int p = 0; p < 5; p++) begin
         write_merge_limit(limits[p]);
         req_idle_on = (p != 0);
         rsp_idle_on = (p > 1);
         if (p == 2) begin
            // full set plus dropped words, the last one ending the set
            add_gene_set(SET_DEPTH + 2);
            hold_req++;
         end
         added = 0;
         while (added < 4) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
            add_gene_set(n);
            added += n;
         end
         drain_and_settle();
      end

      if (fail_count == 0) begin
         $display("[umi_nearest_hamming_merge_core] OK");
      end else begin
         $display("[umi_nearest_hamming_merge_core] ERROR");
      end
      $finish;
   end

endmodule
